FILE: hw/rtl/spectrum_row_max_decimate_colorize_assert.svh
// Assertion macros shared by the spectrum row decimator RTL
`ifndef SPECTRUM_ROW_MAX_DECIMATE_COLORIZE_ASSERT_SVH
`define SPECTRUM_ROW_MAX_DECIMATE_COLORIZE_ASSERT_SVH

// Same-cycle implication, clocked on clock, off during reset
`define SRMDC_ASSERT_IMPLIES(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset
`define SRMDC_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: hw/rtl/srmdc_pkg.sv
// Shared types and constants for the spectrum row decimator and colorizer
package srmdc_pkg;

   localparam int CSR_INDEX_W    = 8;
   localparam int CSR_DATA_W     = 24;

   localparam int BINS_CFG_W     = 17;
   localparam int COLS_CFG_W     = 15;
   localparam int FLOOR_W        = 16;
   localparam int SCALE_W        = 24;

   localparam int COLUMN_INDEX_W = 14;
   localparam int PAL_W          = 8;
   localparam int FRAC_BITS      = 16;
   localparam int ROUND_HALF     = 32768;

   localparam logic [BINS_CFG_W-1:0] BINS_RESET  = 17'd4096;
   localparam logic [COLS_CFG_W-1:0] COLS_RESET  = 15'd4096;
   localparam logic [FLOOR_W-1:0]    FLOOR_RESET = 16'hF880;
   localparam logic [SCALE_W-1:0]    SCALE_RESET = 24'd10445;
   localparam logic [PAL_W-1:0]      PAL_MAX     = 8'hFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BINS    = 8'd0,
      CSR_COLUMNS = 8'd1,
      CSR_FLOOR   = 8'd2,
      CSR_SCALE   = 8'd3
   } csr_reg_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

endpackage

FILE: hw/rtl/srmdc_if.sv
// Item channel interfaces: bin input, column result, register write
interface srmdc_req_if #(
   parameter int LEVEL_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [LEVEL_BITS-1:0] bin_level;

   modport source (output valid, output bin_level, input ready);
   modport sink   (input valid, input bin_level, output ready);
endinterface

interface srmdc_rsp_if;
   import srmdc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [COLUMN_INDEX_W-1:0] column_index;
   logic [PAL_W-1:0]          palette_index;
   logic                      row_done;

   modport source (output valid, output column_index, output palette_index,
                   output row_done, input ready);
   modport sink   (input valid, input column_index, input palette_index,
                   input row_done, output ready);
endinterface

interface srmdc_csr_if;
   import srmdc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/srmdc_div.sv
// Restoring divider, one quotient bit per cycle, for row block geometry
module srmdc_div #(
   parameter int N_W = 17,
   parameter int D_W = 15
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           busy,
   output logic           done,
   output logic [N_W-1:0] quotient,
   output logic [D_W-1:0] remainder
);
   import srmdc_pkg::*;

   localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

   div_state_type  state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [N_W-1:0] quot_ff, quot_in;
   logic [D_W-1:0] rem_ff, rem_in;
   logic [D_W-1:0] dsr_ff, dsr_in;
   logic [D_W:0]   trial;
   logic           fits;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      count_ff <= count_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      trial    = {rem_ff, quot_ff[N_W-1]};
      fits     = trial >= {1'b0, dsr_ff};
      unique case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               state_in = DIV_RUN;
               count_in = '0;
               quot_in  = dividend;
               rem_in   = '0;
               dsr_in   = divisor;
            end
         end
         DIV_RUN: begin
            rem_in   = fits ? D_W'(trial - {1'b0, dsr_ff}) : D_W'(trial);
            quot_in  = {quot_ff[N_W-2:0], fits};
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_W'(N_W - 1)) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            state_in = DIV_IDLE;
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   assign busy      = state_ff != DIV_IDLE;
   assign done      = state_ff == DIV_DONE;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

FILE: hw/rtl/spectrum_row_max_decimate_colorize.sv
// Top level: peak-hold row decimation and palette index mapping of spectrum bins
// Usage:
//   req_ch carries one signed bin level per item, valid/ready handshake.
//   rsp_ch returns one item per finished column: column index, palette index
//   and a row_done flag on the last column of the row.
//   csr_ch writes bins_per_row (0), columns_per_row (1), floor_level (2) and
//   level_scale (3); it is always ready. Unknown indexes are ignored.
// Throughput: one bin per cycle while req_ch.ready is high, set by the
//   single-pass bin stage and the one-multiply colorize pipeline.
// Result path: column results pass stages a, b and c, then the output register.
// Reset and geometry writes: block size bins/columns is found by a bit-serial
//   divider; req_ch.ready stays low until the divider finishes, and the
//   partial row is dropped.
// Stalls: when rsp_ch.ready is low the pipeline fills its three internal stages
//   plus the output register, then drops req_ch.ready; no item is lost.
`include "spectrum_row_max_decimate_colorize_assert.svh"

module spectrum_row_max_decimate_colorize #(
   parameter int MAX_BINS    = 65536,
   parameter int MAX_COLUMNS = 16384,
   parameter int LEVEL_BITS  = 16
) (
   input  logic      clock,
   input  logic      reset,
   srmdc_req_if.sink   req_ch,
   srmdc_rsp_if.source rsp_ch,
   srmdc_csr_if.sink   csr_ch
);
   import srmdc_pkg::*;

   localparam int BIN_W  = $clog2(MAX_BINS + 1);
   localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
   localparam int REM_W  = $clog2(MAX_COLUMNS);
   localparam int SUM_W  = COL_W + 1;
   localparam int BW     = (BIN_W > BINS_CFG_W) ? BIN_W : BINS_CFG_W;
   localparam int CW     = (COL_W > COLS_CFG_W) ? COL_W : COLS_CFG_W;
   localparam int MW     = (BW > CW) ? BW : CW;
   localparam int DIFF_W = LEVEL_BITS + 1;
   localparam int PROD_W = LEVEL_BITS + SCALE_W;

   localparam logic signed [LEVEL_BITS-1:0] LEVEL_MIN = {1'b1, {(LEVEL_BITS-1){1'b0}}};

   // configuration
   logic [BINS_CFG_W-1:0] bins_ff;
   logic [COLS_CFG_W-1:0] cols_ff;
   logic [FLOOR_W-1:0]    floor_ff;
   logic [SCALE_W-1:0]    scale_ff;
   logic                  restart_ff, restart_in;
   logic                  geom_write;

   // geometry
   logic [MW-1:0]    bins_m, cols_m, eff_bins_m, eff_cols_m;
   logic [COL_W-1:0] cols_eff_ff;
   logic [BIN_W-1:0] q_ff, div_quot;
   logic [REM_W-1:0] r_ff;
   logic [COL_W-1:0] div_rem;
   logic             div_start, div_busy, div_done;

   // row state
   logic [BIN_W-1:0]             bin_pos_ff, bin_pos_in, pos_next;
   logic [COL_W-1:0]             col_pos_ff, col_pos_in, col_next;
   logic signed [LEVEL_BITS-1:0] peak_ff, peak_in, peak_next, level;
   logic [BIN_W-1:0]             end_ff, end_in;
   logic [REM_W-1:0]             rem_ff, rem_in;
   logic [SUM_W-1:0]             rem_sum;
   logic                         wrap, blk_done, last;

   // pipeline
   logic a_free, b_free, c_free, o_free, accept, req_ready;
   logic                         a_valid_ff, b_valid_ff, c_valid_ff, o_valid_ff;
   logic [COLUMN_INDEX_W-1:0]    a_col_ff, b_col_ff, c_col_ff, o_col_ff;
   logic                         a_last_ff, b_last_ff, c_last_ff, o_last_ff;
   logic signed [LEVEL_BITS-1:0] a_peak_ff, floor_lvl;
   logic signed [DIFF_W-1:0]     b_diff_ff;
   logic [PROD_W-1:0]            c_prod_ff, prod_in;
   logic [PROD_W:0]              rnd_sum;
   logic [PAL_W-1:0]             o_pal_ff, pal_in;

   // register writes
   assign csr_ch.ready = 1'b1;
   assign geom_write   = csr_ch.valid &&
                         (csr_ch.index == CSR_BINS || csr_ch.index == CSR_COLUMNS);

   always_ff @(posedge clock) begin
      if (reset) begin
         bins_ff  <= BINS_RESET;
         cols_ff  <= COLS_RESET;
         floor_ff <= FLOOR_RESET;
         scale_ff <= SCALE_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_BINS:    bins_ff  <= csr_ch.data[BINS_CFG_W-1:0];
            CSR_COLUMNS: cols_ff  <= csr_ch.data[COLS_CFG_W-1:0];
            CSR_FLOOR:   floor_ff <= csr_ch.data[FLOOR_W-1:0];
            CSR_SCALE:   scale_ff <= csr_ch.data[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // effective bin and column counts
   always_comb begin
      bins_m     = MW'(bins_ff);
      cols_m     = MW'(cols_ff);
      eff_bins_m = bins_m;
      eff_cols_m = cols_m;
      if (bins_m == '0) begin
         eff_bins_m = MW'(1);
      end else if (bins_m > MW'(MAX_BINS)) begin
         eff_bins_m = MW'(MAX_BINS);
      end
      if (cols_m == '0) begin
         eff_cols_m = MW'(1);
      end else if (cols_m > MW'(MAX_COLUMNS)) begin
         eff_cols_m = MW'(MAX_COLUMNS);
      end
      if (eff_cols_m > eff_bins_m) begin
         eff_cols_m = eff_bins_m;
      end
   end

   assign div_start  = restart_ff && !div_busy;
   assign restart_in = geom_write || (restart_ff && div_busy);

   always_ff @(posedge clock) begin
      if (reset) begin
         restart_ff <= 1'b1;
      end else begin
         restart_ff <= restart_in;
      end
      if (div_start) begin
         cols_eff_ff <= COL_W'(eff_cols_m);
      end
      if (div_done) begin
         q_ff <= div_quot;
         r_ff <= REM_W'(div_rem);
      end
   end

   srmdc_div #(
      .N_W(BIN_W),
      .D_W(COL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (BIN_W'(eff_bins_m)),
      .divisor  (COL_W'(eff_cols_m)),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot),
      .remainder(div_rem)
   );

   // handshake
   always_comb begin
      o_free    = !o_valid_ff || rsp_ch.ready;
      c_free    = !c_valid_ff || o_free;
      b_free    = !b_valid_ff || c_free;
      a_free    = !a_valid_ff || b_free;
      req_ready = a_free && !restart_ff && !div_busy;
      accept    = req_ch.valid && req_ready;
   end
   assign req_ch.ready = req_ready;

   // bin stage: peak hold and block boundary tracking
   always_comb begin
      level     = req_ch.bin_level;
      peak_next = (level > peak_ff) ? level : peak_ff;
      pos_next  = bin_pos_ff + 1'b1;
      col_next  = col_pos_ff + 1'b1;
      blk_done  = pos_next >= end_ff;
      last      = col_next >= cols_eff_ff;
      rem_sum   = SUM_W'(rem_ff) + SUM_W'(r_ff);
      wrap      = rem_sum >= SUM_W'(cols_eff_ff);

      bin_pos_in = bin_pos_ff;
      col_pos_in = col_pos_ff;
      peak_in    = peak_ff;
      end_in     = end_ff;
      rem_in     = rem_ff;
      priority if (div_done) begin
         bin_pos_in = '0;
         col_pos_in = '0;
         peak_in    = LEVEL_MIN;
         end_in     = div_quot;
         rem_in     = '0;
      end else if (accept && !blk_done) begin
         bin_pos_in = pos_next;
         peak_in    = peak_next;
      end else if (accept && last) begin
         bin_pos_in = '0;
         col_pos_in = '0;
         peak_in    = LEVEL_MIN;
         end_in     = q_ff;
         rem_in     = '0;
      end else if (accept) begin
         bin_pos_in = pos_next;
         col_pos_in = col_next;
         peak_in    = LEVEL_MIN;
         end_in     = end_ff + q_ff + BIN_W'(wrap);
         rem_in     = wrap ? REM_W'(rem_sum - SUM_W'(cols_eff_ff)) : REM_W'(rem_sum);
      end else begin
         // no item this cycle: hold
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_pos_ff <= '0;
         col_pos_ff <= '0;
         peak_ff    <= LEVEL_MIN;
         end_ff     <= '0;
         rem_ff     <= '0;
      end else begin
         bin_pos_ff <= bin_pos_in;
         col_pos_ff <= col_pos_in;
         peak_ff    <= peak_in;
         end_ff     <= end_in;
         rem_ff     <= rem_in;
      end
   end

   // colorize pipeline
   assign floor_lvl = signed'(LEVEL_BITS'(floor_ff));

   always_comb begin
      prod_in = '0;
      if (!b_diff_ff[DIFF_W-1] && b_diff_ff != '0) begin
         prod_in = PROD_W'(b_diff_ff[LEVEL_BITS-1:0]) * PROD_W'(scale_ff);
      end
      rnd_sum = (PROD_W+1)'(c_prod_ff) + (PROD_W+1)'(ROUND_HALF);
      pal_in  = (|rnd_sum[PROD_W:FRAC_BITS+PAL_W]) ? PAL_MAX
                                                   : rnd_sum[FRAC_BITS+PAL_W-1:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (a_free) a_valid_ff <= accept && blk_done;
         if (b_free) b_valid_ff <= a_valid_ff;
         if (c_free) c_valid_ff <= b_valid_ff;
         if (o_free) o_valid_ff <= c_valid_ff;
      end
      if (accept && blk_done) begin
         a_col_ff  <= COLUMN_INDEX_W'(col_pos_ff);
         a_last_ff <= last;
         a_peak_ff <= peak_next;
      end
      if (b_free) begin
         b_col_ff  <= a_col_ff;
         b_last_ff <= a_last_ff;
         b_diff_ff <= DIFF_W'(a_peak_ff) - DIFF_W'(floor_lvl);
      end
      if (c_free) begin
         c_col_ff  <= b_col_ff;
         c_last_ff <= b_last_ff;
         c_prod_ff <= prod_in;
      end
      if (o_free) begin
         o_col_ff  <= c_col_ff;
         o_last_ff <= c_last_ff;
         o_pal_ff  <= pal_in;
      end
   end

   assign rsp_ch.valid         = o_valid_ff;
   assign rsp_ch.column_index  = o_col_ff;
   assign rsp_ch.palette_index = o_pal_ff;
   assign rsp_ch.row_done      = o_last_ff;

   `SRMDC_ASSERT_IMPLIES(a_col_in_row, !restart_ff && !div_busy, col_pos_ff < cols_eff_ff, "column position past column count")
   `SRMDC_ASSERT_IMPLIES(a_rem_below_cols, !restart_ff && !div_busy, SUM_W'(rem_ff) < SUM_W'(cols_eff_ff), "block remainder not below column count")
   `SRMDC_ASSERT_IMPLIES(a_pos_before_end, !restart_ff && !div_busy, bin_pos_ff < end_ff, "bin position reached block end without a column")
   `SRMDC_ASSERT_NEXT(a_row_restart, div_done, end_ff == q_ff && bin_pos_ff == '0 && col_pos_ff == '0, "row not restarted after geometry update")

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for the spectrum row peak-hold decimator and palette colorizer
module tb_top;
   import srmdc_pkg::*;

   localparam int MAX_BINS     = 65536;
   localparam int MAX_COLUMNS  = 16384;
   localparam int LEVEL_BITS   = 16;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASES       = 20;
   localparam int QUIET_PHASES = 4;

   localparam logic signed [LEVEL_BITS-1:0] LEVEL_LOW  = 16'sh8000;
   localparam logic signed [LEVEL_BITS-1:0] LEVEL_HIGH = 16'sh7FFF;

   typedef struct packed {
      logic [COLUMN_INDEX_W-1:0] column_index;
      logic [PAL_W-1:0]          palette_index;
      logic                      row_done;
   } column_item_type;

   logic clock;
   logic reset;

   srmdc_req_if #(.LEVEL_BITS(LEVEL_BITS)) req_ch();
   srmdc_rsp_if                            rsp_ch();
   srmdc_csr_if                            csr_ch();

   spectrum_row_max_decimate_colorize #(
      .MAX_BINS   (MAX_BINS),
      .MAX_COLUMNS(MAX_COLUMNS),
      .LEVEL_BITS (LEVEL_BITS)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // Predicted block state
   logic [BINS_CFG_W-1:0]     cfg_bins;
   logic [COLS_CFG_W-1:0]     cfg_cols;
   logic signed [FLOOR_W-1:0] cfg_floor;
   logic [SCALE_W-1:0]        cfg_scale;
   int unsigned               row_bin;
   int unsigned               row_col;
   int unsigned               col_end;
   int unsigned               col_rem;
   int                        col_peak;

   column_item_type expected_columns[$];
   int              mismatch_count;
   int unsigned     idle_pct;
   int unsigned     rsp_hold_cycles;
   int unsigned     cycle_count;

   function automatic int unsigned row_bins();
      int unsigned b;
      b = 32'(cfg_bins);
      if (b == 0) b = 1;
      if (b > MAX_BINS) b = MAX_BINS;
      return b;
   endfunction

   function automatic int unsigned row_columns();
      int unsigned c;
      c = 32'(cfg_cols);
      if (c == 0) c = 1;
      if (c > MAX_COLUMNS) c = MAX_COLUMNS;
      if (c > row_bins()) c = row_bins();
      return c;
   endfunction

   function automatic void restart_row();
      row_bin  = 0;
      row_col  = 0;
      col_peak = int'(LEVEL_LOW);
      col_end  = row_bins() / row_columns();
      col_rem  = 0;
   endfunction

   function automatic void apply_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_BINS: begin
            cfg_bins = value[BINS_CFG_W-1:0];
            restart_row();
         end
         CSR_COLUMNS: begin
            cfg_cols = value[COLS_CFG_W-1:0];
            restart_row();
         end
         CSR_FLOOR: cfg_floor = value[FLOOR_W-1:0];
         CSR_SCALE: cfg_scale = value[SCALE_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [PAL_W-1:0] palette_of(int level);
      longint diff;
      longint idx;
      diff = longint'(level) - longint'(cfg_floor);
      if (diff <= 0) return '0;
      idx = (diff * longint'(cfg_scale) + ROUND_HALF) >>> FRAC_BITS;
      return (idx > PAL_MAX) ? PAL_MAX : idx[PAL_W-1:0];
   endfunction

   function automatic void fold_bin(logic signed [LEVEL_BITS-1:0] level);
      int unsigned     nb;
      int unsigned     nc;
      bit              last;
      column_item_type col;
      nb = row_bins();
      nc = row_columns();
      if (int'(level) > col_peak) col_peak = int'(level);
      row_bin++;
      if (row_bin < col_end) return;
      last              = (row_col + 1) >= nc;
      col.column_index  = row_col[COLUMN_INDEX_W-1:0];
      col.palette_index = palette_of(col_peak);
      col.row_done      = last;
      expected_columns.push_back(col);
      if (last) begin
         restart_row();
      end else begin
         row_col++;
         col_peak = int'(LEVEL_LOW);
         col_end += nb / nc;
         col_rem += nb % nc;
         if (col_rem >= nc) begin
            col_rem -= nc;
            col_end++;
         end
      end
   endfunction

   function automatic logic signed [LEVEL_BITS-1:0] random_level();
      int span;
      int lvl;
      case ($urandom_range(0, 9))
         0: return LEVEL_LOW;
         1: return LEVEL_HIGH;
         2, 3, 4, 5: return 16'($urandom);
         default: begin
            span = (cfg_scale == 0) ? 4096 : (255 * 65536) / int'(cfg_scale) + 1;
            if (span > 65535) span = 65535;
            lvl = int'(cfg_floor) + int'($urandom_range(0, span + span / 4)) - span / 8;
            if (lvl < int'(LEVEL_LOW)) lvl = int'(LEVEL_LOW);
            if (lvl > int'(LEVEL_HIGH)) lvl = int'(LEVEL_HIGH);
            return lvl[LEVEL_BITS-1:0];
         end
      endcase
   endfunction

   task automatic send_bin(input logic signed [LEVEL_BITS-1:0] level);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.bin_level <= level;
      do @(posedge clock); while (!req_ch.ready);
      fold_bin(level);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      apply_reg(idx, value);
   endtask

   task automatic csr_idle();
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_columns.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Reset geometry: every bin is its own column
   task automatic test_reset_defaults();
      idle_pct = 20;
      send_bin(LEVEL_LOW);
      send_bin(LEVEL_HIGH);
      send_bin(-16'sd1920);
      send_bin(-16'sd1919);
   endtask

   task automatic test_corner_geometry();
      // zero bins and columns act as one; full scale saturates
      wait_drained();
      write_reg(CSR_BINS, 24'd0);
      write_reg(CSR_COLUMNS, 24'd0);
      write_reg(CSR_FLOOR, 24'd0);
      write_reg(CSR_SCALE, 24'hFFFFFF);
      write_reg(8'hFF, 24'hFFFFFF);
      write_reg(CSR_SCALE + 8'd1, 24'h000000);
      csr_idle();
      send_bin(16'sd1);
      send_bin(16'sd0);
      send_bin(-16'sd1);

      // out of range geometry clamps to the maximum sizes
      wait_drained();
      write_reg(CSR_BINS, 24'hFFFFFF);
      write_reg(CSR_COLUMNS, 24'h007FFF);
      write_reg(CSR_FLOOR, 24'hA58000);
      write_reg(CSR_SCALE, 24'd65536);
      csr_idle();
      send_bin(LEVEL_HIGH);
      send_bin(LEVEL_LOW);
      send_bin(LEVEL_LOW);
      send_bin(LEVEL_LOW);
      send_bin(LEVEL_LOW);

      // zero scale written mid-row
      wait_drained();
      write_reg(CSR_SCALE, 24'd0);
      csr_idle();
      send_bin(LEVEL_HIGH);
      send_bin(LEVEL_HIGH);
      send_bin(LEVEL_HIGH);

      // more columns than bins; levels around the floor
      wait_drained();
      write_reg(CSR_BINS, 24'd5);
      write_reg(CSR_COLUMNS, 24'd20);
      write_reg(CSR_FLOOR, 24'(-16'sd100));
      write_reg(CSR_SCALE, 24'd262144);
      csr_idle();
      send_bin(-16'sd101);
      send_bin(-16'sd100);
      send_bin(-16'sd99);
      send_bin(-16'sd37);
      send_bin(-16'sd36);

      // uneven blocks, half-way rounding
      wait_drained();
      write_reg(CSR_BINS, 24'd7);
      write_reg(CSR_COLUMNS, 24'd3);
      write_reg(CSR_FLOOR, 24'd0);
      write_reg(CSR_SCALE, 24'd32768);
      csr_idle();
      send_bin(16'sd3);
      send_bin(16'sd1);
      send_bin(16'sd0);
      send_bin(16'sd5);
      send_bin(16'sd2);
      send_bin(16'sd4);
      send_bin(16'sd9);
   endtask

   // Long receiver hold-off while bins keep coming
   task automatic test_backpressure();
      wait_drained();
      idle_pct = 0;
      write_reg(CSR_BINS, 24'd8);
      write_reg(CSR_COLUMNS, 24'd8);
      write_reg(CSR_FLOOR, 24'(-16'sd1920));
      write_reg(CSR_SCALE, 24'd10445);
      csr_idle();
      rsp_hold_cycles = 80;
      repeat (40) send_bin(random_level());
   endtask

   task automatic test_random_rows();
      int unsigned      nb;
      int unsigned      n_items;
      logic [CSR_DATA_W-1:0] data;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         if (phase >= PHASES - QUIET_PHASES) idle_pct = 0;
         else if ($urandom_range(0, 2) == 0) idle_pct = 0;
         else idle_pct = $urandom_range(5, 40);

         if (phase == 0 || $urandom_range(0, 3) != 0) begin
            data = 24'($urandom);
            case ($urandom_range(0, 19))
               0: data[BINS_CFG_W-1:0] = '0;
               1: data[BINS_CFG_W-1:0] = BINS_CFG_W'($urandom_range(MAX_BINS + 1, 131071));
               2: data[BINS_CFG_W-1:0] = BINS_CFG_W'(MAX_BINS);
               default: data[BINS_CFG_W-1:0] = BINS_CFG_W'($urandom_range(1, 48));
            endcase
            write_reg(CSR_BINS, data);
            data = 24'($urandom);
            case ($urandom_range(0, 19))
               0: data[COLS_CFG_W-1:0] = '0;
               1: data[COLS_CFG_W-1:0] = COLS_CFG_W'($urandom_range(MAX_COLUMNS + 1, 32767));
               2: data[COLS_CFG_W-1:0] = COLS_CFG_W'(MAX_COLUMNS);
               default: data[COLS_CFG_W-1:0] = COLS_CFG_W'($urandom_range(1, 52));
            endcase
            write_reg(CSR_COLUMNS, data);
         end
         if ($urandom_range(0, 1) == 1) begin
            data = 24'($urandom);
            case ($urandom_range(0, 9))
               0: data[FLOOR_W-1:0] = LEVEL_LOW;
               1: data[FLOOR_W-1:0] = LEVEL_HIGH;
               default: ;
            endcase
            write_reg(CSR_FLOOR, data);
         end
         if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 9))
               0: data = '0;
               1: data = 24'hFFFFFF;
               default: data = CSR_DATA_W'($urandom_range(256, 1 << 20));
            endcase
            write_reg(CSR_SCALE, data);
         end
         if ($urandom_range(0, 7) == 0)
            write_reg(CSR_INDEX_W'($urandom_range(int'(CSR_SCALE) + 1, 255)), 24'($urandom));
         csr_idle();

         nb = row_bins();
         if (nb <= 40) begin
            n_items = nb * ((nb >= 28) ? 1 : 28 / nb);
            if ($urandom_range(0, 3) == 0) n_items += $urandom_range(1, nb);
         end else begin
            n_items = $urandom_range(20, 40);
         end
         repeat (n_items) send_bin(random_level());
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top failed");
      $finish;
   end

   // Result receiver: random stall bursts plus an optional long hold-off
   initial begin
      int unsigned stall;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      column_item_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_columns.size() == 0) begin
               $error("unexpected column item: column_index %0d palette_index %0d row_done %0d",
                      rsp_ch.column_index, rsp_ch.palette_index, rsp_ch.row_done);
               mismatch_count++;
            end else begin
               want = expected_columns.pop_front();
               if (rsp_ch.column_index !== want.column_index) begin
                  $error("column_index: expected %0d, actual %0d",
                         want.column_index, rsp_ch.column_index);
                  mismatch_count++;
               end
               if (rsp_ch.palette_index !== want.palette_index) begin
                  $error("palette_index: expected %0d, actual %0d",
                         want.palette_index, rsp_ch.palette_index);
                  mismatch_count++;
               end
               if (rsp_ch.row_done !== want.row_done) begin
                  $error("row_done: expected %0d, actual %0d", want.row_done, rsp_ch.row_done);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.bin_level = '0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = '0;
      csr_ch.data      = '0;
      mismatch_count   = 0;
      idle_pct         = 0;
      rsp_hold_cycles  = 0;
      cfg_bins         = BINS_RESET;
      cfg_cols         = COLS_RESET;
      cfg_floor        = FLOOR_RESET;
      cfg_scale        = SCALE_RESET;
      restart_row();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_corner_geometry();
      test_backpressure();
      test_random_rows();
      wait_drained();

      if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
